// ===== rtl/core/crc32e_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-32 eight byte engine package
// Shared constants, item types and the byte shift of the reflected CRC-32.
// ----------------------------------------------------------------------------
package crc32e_pkg;

	localparam int          BytesPerItemDef = 8;
	localparam int          DataW           = 64;
	localparam int          DataLanes       = DataW / 8;
	localparam int          CountW          = 4;
	localparam int          CrcW            = 32;
	localparam int          InDataW         = 104;
	localparam int          InUserW         = 2;

	localparam logic [CrcW-1:0] CrcPoly     = 32'hEDB8_8320;
	localparam logic [CrcW-1:0] CrcAllOnes  = 32'hFFFF_FFFF;
	localparam logic [7:0]      SlashByte   = 8'h2F;
	localparam logic [7:0]      DelimReset  = 8'd92;

	typedef struct packed {
		logic            keep;
		logic [CrcW-1:0] term;
	} lane_t;

	typedef struct packed {
		logic            first;
		logic            last;
		logic [CrcW-1:0] start;
	} item_ctl_t;

	// Advance the reflected CRC register by eight zero bits.
	function automatic logic [CrcW-1:0] crc32e_shift8(input logic [CrcW-1:0] crc_in);
		logic [CrcW-1:0] v;
		v = crc_in;
		for (int k = 0; k < 8; k++) begin
			v = v[0] ? ((v >> 1) ^ CrcPoly) : (v >> 1);
		end
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/crc32e_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-32 byte lane
// Decides whether one byte is hashed and registers its CRC contribution.
// ----------------------------------------------------------------------------
module crc32e_lane (
	input  wire logic               clk,
	input  wire logic               load,
	input  wire logic [7:0]         lane_byte,
	input  wire logic               lane_en,
	input  wire logic               path_mode,
	input  wire logic [7:0]         delimiter,
	output      crc32e_pkg::lane_t  lane_s1
);
	import crc32e_pkg::*;

	logic skip;
	lane_t lane_d;

	assign skip = path_mode && ((lane_byte == SlashByte) || (lane_byte == delimiter));

	always_comb begin
		lane_d.keep = lane_en && !skip;
		lane_d.term = crc32e_shift8({{(CrcW-8){1'b0}}, lane_byte});
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lane_s1 <= lane_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/crc32e_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-32 lane merge
// Folds the lane contributions into the running CRC and holds the result.
// ----------------------------------------------------------------------------
module crc32e_merge #(
	parameter int BYTES_PER_ITEM = crc32e_pkg::BytesPerItemDef
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output      logic                        in_ready,
	input  wire crc32e_pkg::lane_t           lanes [BYTES_PER_ITEM],
	input  wire crc32e_pkg::item_ctl_t       ctl,
	output      logic                        out_valid,
	input  wire logic                        out_ready,
	output      logic [crc32e_pkg::CrcW-1:0] crc_value,
	output      logic                        message_done
);
	import crc32e_pkg::*;

	logic            valid_s2;
	logic [CrcW-1:0] running_q;
	logic [CrcW-1:0] crc_s2;
	logic            done_s2;
	logic [CrcW-1:0] crc_next;
	logic            load;

	assign in_ready = !valid_s2 || out_ready;
	assign load     = in_valid && in_ready;

	always_comb begin
		crc_next = ctl.first ? ~ctl.start : running_q;
		for (int i = 0; i < BYTES_PER_ITEM; i++) begin
			if (lanes[i].keep) begin
				crc_next = crc32e_shift8(crc_next) ^ lanes[i].term;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			running_q <= CrcAllOnes;
		end else if (load) begin
			valid_s2  <= 1'b1;
			running_q <= crc_next;
		end else if (out_ready) begin
			valid_s2  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			crc_s2  <= ~crc_next;
			done_s2 <= ctl.last;
		end
	end

	assign out_valid    = valid_s2;
	assign crc_value    = crc_s2;
	assign message_done = done_s2;

endmodule
`default_nettype wire

// ===== rtl/core/crc32_eight_byte_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-32 eight byte engine
// Reflected CRC-32 (0xEDB88320) over up to BYTES_PER_ITEM bytes per item.
// ----------------------------------------------------------------------------
// The engine takes one item every cycle unless m_tready holds it off, and
// returns one result per item, registered in the lane stage and then in the
// merge stage. Stage one holds one lane per byte that registers the byte's
// CRC term and its skip decision; stage two chains the kept lanes onto the
// running CRC combinationally and registers the result; that loop sets the
// item rate. A first item loads the inverse of start_crc; each result is the
// CRC of the bytes so far. In path mode '/' and the configured delimiter byte
// are skipped. Write the delimiter only while no item is in flight.
// ----------------------------------------------------------------------------
module crc32_eight_byte_engine #(
	parameter int BYTES_PER_ITEM = crc32e_pkg::BytesPerItemDef
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wen,
	input  wire logic [7:0]                     cfg_wdata,
	input  wire logic                           s_tvalid,
	output      logic                           s_tready,
	// data_bytes[63:0], byte_count[67:64], start_crc[99:68], zero pad
	input  wire logic [crc32e_pkg::InDataW-1:0] s_tdata,
	// first_item[0], path_mode[1]
	input  wire logic [crc32e_pkg::InUserW-1:0] s_tuser,
	input  wire logic                           s_tlast,
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	// crc_value[31:0]
	output      logic [crc32e_pkg::CrcW-1:0]    m_tdata,
	output      logic                           m_tlast
);
	import crc32e_pkg::*;

	logic [DataW-1:0]  data_bytes;
	logic [CountW-1:0] byte_count;
	logic [CrcW-1:0]   start_crc;
	logic              path_mode;
	logic [7:0]        delimiter_q;
	logic              valid_s1;
	item_ctl_t         ctl_s1;
	logic              load_s1;
	logic              merge_ready;
	lane_t             lanes_s1 [BYTES_PER_ITEM];

	assign data_bytes = s_tdata[DataW-1:0];
	assign byte_count = s_tdata[DataW +: CountW];
	assign start_crc  = s_tdata[DataW+CountW +: CrcW];
	assign path_mode  = s_tuser[1];

	assign s_tready = !valid_s1 || merge_ready;
	assign load_s1  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= DelimReset;
			valid_s1    <= 1'b0;
		end else begin
			if (cfg_wen) begin
				delimiter_q <= cfg_wdata;
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			ctl_s1.first <= s_tuser[0];
			ctl_s1.last  <= s_tlast;
			ctl_s1.start <= start_crc;
		end
	end

	for (genvar g = 0; g < BYTES_PER_ITEM; g++) begin : g_lane
		localparam logic [CountW:0] LaneIdx = (CountW+1)'(g);
		logic [7:0] lane_byte;
		logic       lane_en;

		if (g < DataLanes) begin : g_data
			assign lane_byte = data_bytes[8*g +: 8];
		end else begin : g_zero
			assign lane_byte = 8'h00;
		end

		assign lane_en = {1'b0, byte_count} > LaneIdx;

		crc32e_lane u_lane (
			.clk       (clk),
			.load      (load_s1),
			.lane_byte (lane_byte),
			.lane_en   (lane_en),
			.path_mode (path_mode),
			.delimiter (delimiter_q),
			.lane_s1   (lanes_s1[g])
		);
	end

	crc32e_merge #(
		.BYTES_PER_ITEM (BYTES_PER_ITEM)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (valid_s1),
		.in_ready     (merge_ready),
		.lanes        (lanes_s1),
		.ctl          (ctl_s1),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.crc_value    (m_tdata),
		.message_done (m_tlast)
	);

endmodule
`default_nettype wire

// ===== rtl/core/crc32e_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-32 engine port checker
// Watches the ports of the engine for item count and timing slips.
// ----------------------------------------------------------------------------
module crc32e_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic [crc32e_pkg::InDataW-1:0] s_tdata,
	input wire logic [crc32e_pkg::InUserW-1:0] s_tuser,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [crc32e_pkg::CrcW-1:0]    m_tdata,
	input wire logic                           m_tlast
);
	import crc32e_pkg::*;

	logic       s_acc;
	logic       m_acc;
	logic [1:0] inflight_q;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 2'd0;
		end else if (s_acc && !m_acc) begin
			inflight_q <= inflight_q + 2'd1;
		end else if (m_acc && !s_acc) begin
			inflight_q <= inflight_q - 2'd1;
		end
	end

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != 2'd0)
		else $error("result with no item in flight");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3 && (inflight_q != 2'd0 || s_tready))
		else $error("in-flight count out of range or idle engine not ready");

	a_empty_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && inflight_q == 2'd0 && s_tuser[0] && s_tdata[DataW +: CountW] == '0
		|-> ##2 m_tvalid && m_tdata == $past(s_tdata[DataW+CountW +: CrcW], 2))
		else $error("empty first item did not report start value");

endmodule

bind crc32_eight_byte_engine crc32e_checker u_crc32e_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire

// ===== test/crc32_eight_byte_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 eight byte engine testbench
// Drives the engine with a directed set of items, then random messages with
// path bytes mixed in, under three sender/receiver idling patterns and a long
// receiver hold-off. A scoreboard tracks the running CRC and the delimiter,
// and checks every result against its own prediction in order.
// ----------------------------------------------------------------------------
module crc32_eight_byte_engine_tb;
	import crc32e_pkg::*;

	localparam int StallLimit  = 5000;
	localparam int HoldCycles  = 400;
	localparam int DrainCycles = 6;

	typedef struct {
		logic [CrcW-1:0] crc;
		logic            done;
	} crc_result_t;

	class crc_tracker;
		logic [CrcW-1:0] running;
		logic [7:0]      delim;
		crc_result_t     crc_due[$];
		int              mismatches;

		function new();
			running = CrcAllOnes;
			delim = DelimReset;
			mismatches = 0;
		endfunction

		function void set_delim(input logic [7:0] v);
			delim = v;
		endfunction

		function int pending();
			return crc_due.size();
		endfunction

		function void note_item(input logic [DataW-1:0] data, input logic [CountW-1:0] count,
			input logic first, input logic last, input logic [CrcW-1:0] start, input logic path);
			int n;
			logic [7:0] b;
			logic [CrcW-1:0] v;
			crc_result_t r;
			n = (count > DataLanes) ? DataLanes : int'(count);
			v = first ? ~start : running;
			for (int i = 0; i < n; i++) begin
				b = data[8*i +: 8];
				if (!(path && (b == SlashByte || b == delim))) begin
					v = v ^ {24'd0, b};
					for (int k = 0; k < 8; k++)
						v = v[0] ? ((v >> 1) ^ CrcPoly) : (v >> 1);
				end
			end
			running = v;
			r.crc = ~v;
			r.done = last;
			crc_due.push_back(r);
		endfunction

		function void check_crc(input logic [CrcW-1:0] crc, input logic done);
			crc_result_t r;
			if (crc_due.size() == 0) begin
				$error("crc_value: no result expected, actual %h", crc);
				mismatches++;
			end else begin
				r = crc_due.pop_front();
				if (crc !== r.crc) begin
					$error("crc_value: expected %h, actual %h", r.crc, crc);
					mismatches++;
				end
				if (done !== r.done) begin
					$error("message_done: expected %b, actual %b", r.done, done);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wen = 1'b0;
	logic [7:0]         cfg_wdata = DelimReset;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [InDataW-1:0] s_tdata = '0;
	logic [InUserW-1:0] s_tuser = '0;
	logic               s_tlast = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [CrcW-1:0]    m_tdata;
	logic               m_tlast;

	logic               in_fire = 1'b0;
	logic               out_fire = 1'b0;
	int                 send_idle = 0;
	int                 recv_idle = 0;
	int                 hold_reqs = 0;
	crc_tracker         tracker;

	crc32_eight_byte_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		in_fire = arst_n && s_tvalid && s_tready;
		out_fire = arst_n && m_tvalid && m_tready;
		if (in_fire)
			tracker.note_item(s_tdata[63:0], s_tdata[67:64], s_tuser[0], s_tlast,
				s_tdata[99:68], s_tuser[1]);
		if (out_fire)
			tracker.check_crc(m_tdata, m_tlast);
	end

	initial begin
		int hold_left;
		int hold_served;
		hold_left = 0;
		hold_served = 0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_reqs) begin
				hold_served = hold_reqs;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	initial begin
		int stalled;
		stalled = 0;
		@(posedge arst_n);
		while (stalled < StallLimit) begin
			@(posedge clk);
			if (in_fire || out_fire)
				stalled = 0;
			else
				stalled++;
		end
		$display("crc32_eight_byte_engine verification failed");
		$finish;
	end

	task automatic send_item(input logic [DataW-1:0] data, input logic [CountW-1:0] count,
		input logic first, input logic last, input logic [CrcW-1:0] start, input logic path);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, start, count, data};
		s_tuser <= {path, first};
		s_tlast <= last;
		do @(posedge clk); while (!in_fire);
	endtask

	task automatic write_delim(input logic [7:0] v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		tracker.set_delim(v);
	endtask

	function automatic logic [7:0] lane_byte();
		case ($urandom_range(7))
			0, 1: return SlashByte;
			2: return tracker.delim;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [CountW-1:0] item_count();
		case ($urandom_range(19))
			0: return '0;
			1: return 4'($urandom_range(15, 9));
			default: return 4'($urandom_range(8, 1));
		endcase
	endfunction

	task automatic random_phase(input int n);
		int sent;
		int len;
		logic [DataW-1:0] data;
		logic [CrcW-1:0] start;
		logic msg_path;
		logic first;
		logic last;
		logic path;
		sent = 0;
		while (sent < n) begin
			len = $urandom_range(6, 1);
			msg_path = 1'($urandom_range(1));
			start = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom);
			for (int j = 0; j < len; j++) begin
				for (int i = 0; i < DataLanes; i++)
					data[8*i +: 8] = lane_byte();
				first = (j == 0);
				last = (j == len - 1);
				path = msg_path;
				if ($urandom_range(9) == 0) begin
					first = 1'($urandom_range(1));
					last = 1'($urandom_range(1));
					path = 1'($urandom_range(1));
					data = {32'($urandom), 32'($urandom)};
				end
				send_item(data, item_count(), first, last,
					first ? start : 32'($urandom), path);
				sent++;
			end
		end
	endtask

	initial begin
		logic [DataW-1:0] word;
		tracker = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(64'h3837_3635_3433_3231, 4'd8, 1'b1, 1'b0, 32'd0, 1'b0);
		send_item(64'h39, 4'd1, 1'b0, 1'b1, 32'hDEAD_BEEF, 1'b0);
		send_item('1, 4'd8, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
		send_item('0, 4'd8, 1'b1, 1'b1, 32'd0, 1'b0);
		send_item({32'($urandom), 32'($urandom)}, 4'd0, 1'b1, 1'b0, 32'($urandom), 1'b0);
		send_item({32'($urandom), 32'($urandom)}, 4'd0, 1'b0, 1'b0, 32'd0, 1'b0);
		send_item({32'($urandom), 32'($urandom)}, 4'd15, 1'b0, 1'b0, 32'($urandom), 1'b0);
		send_item({32'($urandom), 32'($urandom)}, 4'd9, 1'b0, 1'b1, 32'd0, 1'b1);
		send_item(64'h2F5C_2F41_5C5C_422F, 4'd8, 1'b1, 1'b0, 32'd0, 1'b1);
		send_item(64'h2F5C_2F41_5C5C_422F, 4'd8, 1'b1, 1'b1, 32'd0, 1'b0);
		send_item({32'($urandom), 32'($urandom)}, 4'd4, 1'b0, 1'b0, 32'($urandom), 1'b1);
		send_item({32'($urandom), 32'($urandom)}, 4'd8, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0);
		send_item({8{SlashByte}}, 4'd8, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
		send_item({8{DelimReset}}, 4'd8, 1'b1, 1'b1, 32'($urandom), 1'b1);
		send_item('0, 4'd10, 1'b1, 1'b1, 32'($urandom), 1'b1);
		for (int c = 1; c <= DataLanes; c++) begin
			for (int i = 0; i < DataLanes; i++)
				word[8*i +: 8] = lane_byte();
			send_item(word, 4'(c), c == 1, c == DataLanes, 32'($urandom),
				1'($urandom_range(1)));
		end

		write_delim(8'hFF);
		send_idle = 26;
		recv_idle <= 66;
		random_phase(200);

		write_delim(8'h00);
		send_idle = 66;
		recv_idle <= 26;
		random_phase(200);

		write_delim(8'($urandom));
		send_idle = 0;
		recv_idle <= 0;
		random_phase(50);
		hold_reqs <= hold_reqs + 1;
		random_phase(150);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("crc32_eight_byte_engine verification clean");
		else
			$display("crc32_eight_byte_engine verification failed");
		$finish;
	end

endmodule
